// ===== rtl/pfsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfsc_pkg
// Shared types and constants of the PID fan speed controller.
// ----------------------------------------------------------------------------
package pfsc_pkg;

	// field widths
	localparam int ID_W    = 11;
	localparam int LEN_W   = 4;
	localparam int TEMP_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int FAN_W   = 23;
	localparam int ERR_W   = 17;
	localparam int SUM_W   = 32;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	// mode codes
	localparam logic [1:0] MODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_IDLE    = 2'd1;
	localparam logic [1:0] MODE_COOLING = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_SET_POINT = 3'd0;
	localparam logic [CIDX_W-1:0] REG_KP        = 3'd1;
	localparam logic [CIDX_W-1:0] REG_KI_DT     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_KD_DIV_DT = 3'd3;
	localparam logic [CIDX_W-1:0] REG_TEMP_ID   = 3'd4;

	// reset values
	localparam logic signed [TEMP_W-1:0] SET_POINT_INIT = 16'sd2560; // 10.0 in Q8.8
	localparam logic [ID_W-1:0]          TEMP_ID_INIT   = 11'd256;
	localparam logic [FAN_W-1:0]         FAN_MAX        = 23'h7FFFFF;

	typedef struct packed {
		logic signed [TEMP_W-1:0] set_point;
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki_dt;
		logic signed [GAIN_W-1:0] kd_div_dt;
		logic [ID_W-1:0]          temperature_id;
	} cfg_t;

	typedef struct packed {
		logic step;   // matching frame leaves the pass: commit PID state
		logic clear;  // INIT mode pass: zero PID state
	} pid_ctrl_t;

	typedef struct packed {
		logic             drive_pos;  // truncated Q.8 drive above zero
		logic [FAN_W-1:0] drive_sat;  // drive clipped to fan range
	} pid_res_t;

endpackage
`default_nettype wire

// ===== rtl/pfsc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfsc_cfg_regs
// Configuration register file; INIT mode reloads the set point.
// ----------------------------------------------------------------------------
module pfsc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [pfsc_pkg::CIDX_W-1:0]    wr_index,
	input  wire logic [pfsc_pkg::CDATA_W-1:0]   wr_data,
	input  wire logic                           reload,
	output pfsc_pkg::cfg_t                      cfg
);

	pfsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_point      <= pfsc_pkg::SET_POINT_INIT;
			cfg_q.kp             <= '0;
			cfg_q.ki_dt          <= '0;
			cfg_q.kd_div_dt      <= '0;
			cfg_q.temperature_id <= pfsc_pkg::TEMP_ID_INIT;
		end else begin
			if (wr_en) begin
				case (wr_index)
					pfsc_pkg::REG_SET_POINT: cfg_q.set_point <= $signed(wr_data);
					pfsc_pkg::REG_KP:        cfg_q.kp        <= $signed(wr_data);
					pfsc_pkg::REG_KI_DT:     cfg_q.ki_dt     <= $signed(wr_data);
					pfsc_pkg::REG_KD_DIV_DT: cfg_q.kd_div_dt <= $signed(wr_data);
					pfsc_pkg::REG_TEMP_ID:
						cfg_q.temperature_id <= wr_data[pfsc_pkg::ID_W-1:0];
					default: ;
				endcase
			end
			if (reload) begin
				cfg_q.set_point <= pfsc_pkg::SET_POINT_INIT;
			end
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/pfsc_pid_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfsc_pid_dp
// PID datapath: error, saturating error sum, three products, drive.
// ----------------------------------------------------------------------------
module pfsc_pid_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pfsc_pkg::cfg_t                     cfg,
	input  wire logic signed [pfsc_pkg::TEMP_W-1:0] temp,
	input  wire pfsc_pkg::pid_ctrl_t                ctrl,
	output pfsc_pkg::pid_res_t                      res
);

	localparam int FULL_W = 50;

	logic signed [pfsc_pkg::SUM_W-1:0] error_sum_q;
	logic signed [pfsc_pkg::ERR_W-1:0] prev_error_q;

	logic signed [pfsc_pkg::ERR_W-1:0] err;
	logic signed [pfsc_pkg::SUM_W:0]   sum_wide;
	logic signed [pfsc_pkg::SUM_W-1:0] sum_next;
	logic signed [pfsc_pkg::ERR_W:0]   derr;
	logic signed [32:0]                p_term;
	logic signed [47:0]                i_term;
	logic signed [33:0]                d_term;
	logic signed [FULL_W-1:0]          full;

	always_comb begin
		err = $signed({temp[pfsc_pkg::TEMP_W-1], temp})
		    - $signed({cfg.set_point[pfsc_pkg::TEMP_W-1], cfg.set_point});
		sum_wide = $signed({error_sum_q[pfsc_pkg::SUM_W-1], error_sum_q})
		         + $signed({{(pfsc_pkg::SUM_W+1-pfsc_pkg::ERR_W){err[pfsc_pkg::ERR_W-1]}}, err});
		// clip to the 32-bit signed range
		if (sum_wide[pfsc_pkg::SUM_W] != sum_wide[pfsc_pkg::SUM_W-1]) begin
			sum_next = sum_wide[pfsc_pkg::SUM_W] ? $signed({1'b1, {(pfsc_pkg::SUM_W-1){1'b0}}})
			                                     : $signed({1'b0, {(pfsc_pkg::SUM_W-1){1'b1}}});
		end else begin
			sum_next = sum_wide[pfsc_pkg::SUM_W-1:0];
		end
		derr = $signed({err[pfsc_pkg::ERR_W-1], err})
		     - $signed({prev_error_q[pfsc_pkg::ERR_W-1], prev_error_q});
		p_term = cfg.kp * err;
		i_term = cfg.ki_dt * sum_next;
		d_term = cfg.kd_div_dt * derr;
		full = $signed({{(FULL_W-33){p_term[32]}}, p_term})
		     + $signed({{(FULL_W-48){i_term[47]}}, i_term})
		     + $signed({{(FULL_W-34){d_term[33]}}, d_term});
		// positive after dropping eight fraction bits
		res.drive_pos = !full[FULL_W-1] && (|full[FULL_W-2:8]);
		if (|full[FULL_W-2:pfsc_pkg::FAN_W+8]) begin
			res.drive_sat = pfsc_pkg::FAN_MAX;
		end else begin
			res.drive_sat = full[pfsc_pkg::FAN_W+7:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else if (ctrl.clear) begin
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else if (ctrl.step) begin
			error_sum_q  <= sum_next;
			prev_error_q <= err;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pid_fan_speed_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pid_fan_speed_controller
// A frame accepted into the frame register (_s1) moves its result (if any)
// into the result register. Throughput: one frame per cycle unless fan_speed
// stalls; the error-sum feedback closes within the single s1-to-result pass.
// Reset (arst_n low): registers to their reset values, mode INIT, PID state
// zero, both pipeline slots empty.
// ----------------------------------------------------------------------------
// One frame is one control tick. A frame whose id matches temperature_id
// and whose length is nonzero runs a PID step; any other frame has drive 0.
// The mode machine then decides whether a fan_speed transaction goes out:
//   INIT    - clears PID state, reloads the set point, moves to IDLE, silent.
//   IDLE    - positive drive: to COOLING, silent; else sends speed 0.
//   COOLING - non-positive drive: to IDLE, silent; else sends clipped drive.
// The unused mode code behaves as INIT.
// The frame register (_s1) advances whenever the result register is empty
// or is being taken, so a waiting result holds off new frames only once the
// frame register is occupied as well.
// ----------------------------------------------------------------------------
module pid_fan_speed_controller (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// frame channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [pfsc_pkg::ID_W-1:0]           frame_id,
	input  wire logic [pfsc_pkg::LEN_W-1:0]          frame_len,
	input  wire logic signed [pfsc_pkg::TEMP_W-1:0]  temperature,
	// fan speed channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [pfsc_pkg::FAN_W-1:0]               fan_speed,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pfsc_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [pfsc_pkg::CDATA_W-1:0]        cfg_data
);

	// frame register
	logic                               valid_s1;
	logic [pfsc_pkg::ID_W-1:0]          frame_id_s1;
	logic [pfsc_pkg::LEN_W-1:0]         frame_len_s1;
	logic signed [pfsc_pkg::TEMP_W-1:0] temperature_s1;

	// result register and mode
	logic                               out_valid_q;
	logic [pfsc_pkg::FAN_W-1:0]         fan_speed_q;
	logic [1:0]                         mode_q;

	logic                               adv;
	logic                               accept;
	logic                               match;
	logic                               is_init;
	logic                               emit;
	logic [pfsc_pkg::FAN_W-1:0]         emit_val;
	logic [1:0]                         mode_next;

	pfsc_pkg::cfg_t                     cfg;
	pfsc_pkg::pid_ctrl_t                ctrl;
	pfsc_pkg::pid_res_t                 res;

	// frame leaves s1 when the result slot is free or draining this cycle
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign match   = (frame_id_s1 == cfg.temperature_id) && (frame_len_s1 != '0);
	assign is_init = (mode_q != pfsc_pkg::MODE_IDLE) && (mode_q != pfsc_pkg::MODE_COOLING);

	assign ctrl = '{step: adv && match, clear: adv && is_init};

	pfsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.reload   (ctrl.clear),
		.cfg      (cfg)
	);

	pfsc_pid_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.temp   (temperature_s1),
		.ctrl   (ctrl),
		.res    (res)
	);

	// mode decision; non-matching frames count as zero drive
	always_comb begin
		logic pos;
		pos       = match && res.drive_pos;
		emit      = 1'b0;
		emit_val  = '0;
		mode_next = mode_q;
		case (mode_q)
			pfsc_pkg::MODE_IDLE: begin
				if (pos) begin
					mode_next = pfsc_pkg::MODE_COOLING;
				end else begin
					emit = 1'b1;
				end
			end
			pfsc_pkg::MODE_COOLING: begin
				if (!pos) begin
					mode_next = pfsc_pkg::MODE_IDLE;
				end else begin
					emit     = 1'b1;
					emit_val = res.drive_sat;
				end
			end
			default: begin
				mode_next = pfsc_pkg::MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= pfsc_pkg::MODE_INIT;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= emit;
				mode_q      <= mode_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_id_s1    <= frame_id;
			frame_len_s1   <= frame_len;
			temperature_s1 <= temperature;
		end
		if (adv && emit) begin
			fan_speed_q <= emit_val;
		end
	end

	assign out_valid = out_valid_q;
	assign fan_speed = fan_speed_q;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - PID fan speed controller testbench
// Sends bus frames through the frame channel and programs the gains, set
// point and temperature frame id through the register port. Every accepted
// frame runs through a cycle-free copy of the controller (PID step, then the
// INIT / IDLE / COOLING mode machine). Each fan_speed transaction is compared
// with the oldest predicted speed. The speed channel sees random stalls.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT = 400_000;
	localparam longint SUM_HI      = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SUM_LO      = -SUM_HI - 1;
	// index past the last register; writes to it must be dropped
	localparam logic [pfsc_pkg::CIDX_W-1:0] REG_UNUSED = 3'd6;

	typedef struct packed {
		logic                        drain;  // hold this frame until all speeds are back
		logic [pfsc_pkg::ID_W-1:0]   id;
		logic [pfsc_pkg::LEN_W-1:0]  len;
		logic [pfsc_pkg::TEMP_W-1:0] temp;
	} frame_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = ~clk;
	end

	// DUT inputs, all driven to known values from time zero
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	logic [pfsc_pkg::ID_W-1:0]          frame_id    = '0;
	logic [pfsc_pkg::LEN_W-1:0]         frame_len   = '0;
	logic signed [pfsc_pkg::TEMP_W-1:0] temperature = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	logic [pfsc_pkg::FAN_W-1:0]         fan_speed;
	logic                               cfg_valid   = 1'b0;
	logic                               cfg_ready;
	logic [pfsc_pkg::CIDX_W-1:0]        cfg_index   = '0;
	logic [pfsc_pkg::CDATA_W-1:0]       cfg_data    = '0;

	pid_fan_speed_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_id   (frame_id),
		.frame_len  (frame_len),
		.temperature(temperature),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.fan_speed  (fan_speed),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Controller copy: register shadows and PID / mode state
	// ------------------------------------------------------------------------
	logic signed [pfsc_pkg::TEMP_W-1:0] sp       = pfsc_pkg::SET_POINT_INIT;
	logic signed [pfsc_pkg::GAIN_W-1:0] gain_p   = '0;
	logic signed [pfsc_pkg::GAIN_W-1:0] gain_i   = '0;
	logic signed [pfsc_pkg::GAIN_W-1:0] gain_d   = '0;
	logic [pfsc_pkg::ID_W-1:0]          tid      = pfsc_pkg::TEMP_ID_INIT;
	logic [1:0]                         ctl_mode = pfsc_pkg::MODE_INIT;
	logic signed [pfsc_pkg::SUM_W-1:0]  integ    = '0;
	logic signed [pfsc_pkg::ERR_W-1:0]  prev_err = '0;

	logic [pfsc_pkg::FAN_W-1:0] expected_speeds[$];
	frame_t                     frame_q[$];

	int  frames_sent    = 0;
	int  frames_taken   = 0;
	int  speeds_seen    = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  calm           = 1'b0;  // no idling on either side in the last phase

	// One control tick: optional PID step, then the mode machine.
	function automatic void pid_tick(input logic [pfsc_pkg::ID_W-1:0] id,
			input logic [pfsc_pkg::LEN_W-1:0] len,
			input logic signed [pfsc_pkg::TEMP_W-1:0] temp);
		logic signed [pfsc_pkg::ERR_W-1:0] err;
		longint                            acc;
		longint                            full;
		longint                            drive;
		drive = 0;
		if (id == tid && len != '0) begin
			err = temp - sp;  // exact in 17 bits
			acc = longint'(integ) + longint'(err);
			if (acc > SUM_HI) acc = SUM_HI;
			if (acc < SUM_LO) acc = SUM_LO;
			integ = 32'(acc);
			full = longint'(gain_p) * longint'(err)
				+ longint'(gain_i) * longint'(integ)
				+ longint'(gain_d) * (longint'(err) - longint'(prev_err));
			prev_err = err;
			// Q.16 down to Q.8; a small positive sum truncates to zero
			if (full > 0) drive = full >>> 8;
		end
		case (ctl_mode)
			pfsc_pkg::MODE_IDLE: begin
				if (drive > 0) ctl_mode = pfsc_pkg::MODE_COOLING;
				else expected_speeds.push_back('0);
			end
			pfsc_pkg::MODE_COOLING: begin
				if (drive <= 0) ctl_mode = pfsc_pkg::MODE_IDLE;
				else if (drive > longint'(pfsc_pkg::FAN_MAX))
					expected_speeds.push_back(pfsc_pkg::FAN_MAX);
				else expected_speeds.push_back(drive[pfsc_pkg::FAN_W-1:0]);
			end
			default: begin
				// INIT and the unused code: wipe PID state, reload set point
				integ    = '0;
				prev_err = '0;
				sp       = pfsc_pkg::SET_POINT_INIT;
				ctl_mode = pfsc_pkg::MODE_IDLE;
			end
		endcase
	endfunction

	task automatic log_mismatch(input string what, input logic [pfsc_pkg::FAN_W-1:0] got,
			input logic [pfsc_pkg::FAN_W-1:0] want);
		mismatch_count++;
		$display("MISMATCH %s: fan_speed got %0d expected %0d at %0t", what, got, want,
			$time);
	endtask

	// ------------------------------------------------------------------------
	// Frame driver: launches at the falling edge, holds until taken
	// ------------------------------------------------------------------------
	int in_gap = 0;

	always @(negedge clk) begin : drive_frames
		frame_t f;
		if (arst_n && (!in_valid || frames_taken == frames_sent)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (frame_q.size() != 0 &&
					!(frame_q[0].drain && expected_speeds.size() != 0)) begin
				f = frame_q.pop_front();
				frame_id    <= f.id;
				frame_len   <= f.len;
				temperature <= f.temp;
				in_valid    <= 1'b1;
				frames_sent++;
				// occasional idle burst after this frame
				if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// frame accepted: run it through the controller copy
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			frames_taken++;
			pid_tick(frame_id, frame_len, temperature);
		end
	end

	// ------------------------------------------------------------------------
	// Speed receiver: random stall bursts, plus one long hold-off so the
	// frame side backs up and in_stall has to rise
	// ------------------------------------------------------------------------
	int  stall_left = 0;
	int  hold_left  = 0;
	bit  long_hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!long_hold_done && speeds_seen >= 40) begin
			long_hold_done = 1'b1;
			hold_left      = 299;
			out_stall     <= 1'b1;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// speed transaction: compare against the oldest prediction
	always @(posedge clk) begin : check_speed
		logic [pfsc_pkg::FAN_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			speeds_seen++;
			if (expected_speeds.size() == 0) begin
				log_mismatch("unexpected transaction", fan_speed, '0);
			end else begin
				want = expected_speeds.pop_front();
				if (fan_speed !== want) log_mismatch("wrong speed", fan_speed, want);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------------

	// Register write; the shadow is updated on the same edge as the DUT.
	task automatic write_reg(input logic [pfsc_pkg::CIDX_W-1:0] idx,
			input logic [pfsc_pkg::CDATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pfsc_pkg::REG_SET_POINT: sp     = data;
			pfsc_pkg::REG_KP:        gain_p = data;
			pfsc_pkg::REG_KI_DT:     gain_i = data;
			pfsc_pkg::REG_KD_DIV_DT: gain_d = data;
			pfsc_pkg::REG_TEMP_ID:   tid    = data[pfsc_pkg::ID_W-1:0];
			default: ;  // out of range, dropped
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_frame(input logic [pfsc_pkg::ID_W-1:0] id,
			input logic [pfsc_pkg::LEN_W-1:0] len, input logic [pfsc_pkg::TEMP_W-1:0] temp);
		frame_t f;
		f = '{drain: 1'b0, id: id, len: len, temp: temp};
		frame_q.push_back(f);
	endtask

	// Mostly well-formed temperature frames around the given center, some
	// noise frames; optionally one frame midway waits for a full drain.
	task automatic queue_random_frames(input int count,
			input logic signed [pfsc_pkg::TEMP_W-1:0] center, input bit pause_midway);
		frame_t f;
		int     pick;
		int     offs;
		for (int k = 0; k < count; k++) begin
			f.drain = pause_midway && (k == count / 2);
			if ($urandom_range(0, 9) < 7) begin
				f.id  = tid;
				f.len = pfsc_pkg::LEN_W'($urandom_range(1, 15));
			end else begin
				f.id  = pfsc_pkg::ID_W'($urandom);
				f.len = pfsc_pkg::LEN_W'($urandom_range(0, 15));
			end
			pick = $urandom_range(0, 7);
			if (pick < 5) begin
				// near the set point so the mode machine keeps flipping
				offs   = $urandom_range(0, 1023);
				offs   = offs - 512;
				f.temp = pfsc_pkg::TEMP_W'(center + offs);
			end else if (pick < 7) begin
				f.temp = pfsc_pkg::TEMP_W'($urandom);
			end else begin
				case ($urandom_range(0, 2))
					0:       f.temp = 16'h8000;
					1:       f.temp = 16'h7FFF;
					default: f.temp = 16'h0000;
				endcase
			end
			frame_q.push_back(f);
		end
	endtask

	// All frames taken and all speeds back, then let the pipe run dry
	// (silent frames may still be in flight).
	task automatic wait_for_quiet();
		while (!(frame_q.size() == 0 && frames_taken == frames_sent &&
				expected_speeds.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: moderate gains. The set point written here is wiped by
		// the INIT tick on the first frame.
		write_reg(pfsc_pkg::REG_SET_POINT, 16'h7FFF);
		write_reg(pfsc_pkg::REG_KP,        16'h0100);
		write_reg(pfsc_pkg::REG_KI_DT,     16'h0010);
		write_reg(pfsc_pkg::REG_KD_DIV_DT, 16'h0040);
		write_reg(pfsc_pkg::REG_TEMP_ID,   16'h0123);

		queue_frame(11'h123, 4'd1,  16'h0000);  // INIT tick, silent
		queue_frame(11'h7FF, 4'd8,  16'h7FFF);  // other id: drive 0
		queue_frame(11'h123, 4'd0,  16'h7FFF);  // empty frame: drive 0
		queue_frame(11'h123, 4'd15, 16'd2560);  // length above eight, zero error
		queue_frame(11'h123, 4'd8,  16'h8000);  // coldest reading
		queue_frame(11'h123, 4'd1,  16'h7FFF);  // hottest: IDLE to COOLING
		queue_frame(11'h123, 4'd2,  16'h7FFF);  // COOLING sends drive
		queue_frame(11'h123, 4'd4,  16'h4000);
		queue_frame(11'h000, 4'd3,  16'h1234);  // other id in COOLING: to IDLE
		queue_frame(11'h123, 4'd0,  16'h0000);  // empty frame in IDLE
		queue_frame(11'h123, 4'd7,  16'd3072);  // just above set point
		queue_frame(11'h123, 4'd5,  16'h8001);  // far below: back down
		queue_random_frames(250, pfsc_pkg::SET_POINT_INIT, 1'b1);
		wait_for_quiet();

		// Phase 2: extreme positive P and I, most negative D and set point;
		// drive clips at the top of the fan range.
		write_reg(pfsc_pkg::REG_SET_POINT, 16'h8000);
		write_reg(pfsc_pkg::REG_KP,        16'h7FFF);
		write_reg(pfsc_pkg::REG_KI_DT,     16'h7FFF);
		write_reg(pfsc_pkg::REG_KD_DIV_DT, 16'h8000);
		write_reg(pfsc_pkg::REG_TEMP_ID,   16'h07FF);
		queue_frame(11'h7FF, 4'd8, 16'h7FFF);
		queue_frame(11'h7FF, 4'd8, 16'h7FFF);
		queue_frame(11'h7FF, 4'd8, 16'h7FFF);
		queue_random_frames(120, sp, 1'b0);
		wait_for_quiet();

		// Phase 3: the opposite extremes, id zero, dropped write to a
		// register index that does not exist
		write_reg(pfsc_pkg::REG_SET_POINT, 16'h7FFF);
		write_reg(pfsc_pkg::REG_KP,        16'h8000);
		write_reg(pfsc_pkg::REG_KI_DT,     16'h8000);
		write_reg(pfsc_pkg::REG_KD_DIV_DT, 16'h7FFF);
		write_reg(pfsc_pkg::REG_TEMP_ID,   16'h0000);
		write_reg(REG_UNUSED,              16'hFFFF);
		queue_random_frames(120, sp, 1'b0);
		wait_for_quiet();

		// Phase 4: unity-ish P only; errors under one degree truncate to a
		// zero drive, which counts as non-positive
		write_reg(pfsc_pkg::REG_SET_POINT, 16'h0000);
		write_reg(pfsc_pkg::REG_KP,        16'h0001);
		write_reg(pfsc_pkg::REG_KI_DT,     16'h0000);
		write_reg(pfsc_pkg::REG_KD_DIV_DT, 16'h0000);
		write_reg(pfsc_pkg::REG_TEMP_ID,   16'h0555);
		queue_frame(11'h555, 4'd1, 16'h7FFF);
		queue_frame(11'h555, 4'd2, 16'h7FFF);
		queue_frame(11'h555, 4'd3, 16'h0040);  // full sum 64 -> drive 0
		queue_frame(11'h555, 4'd4, 16'h0040);
		queue_frame(11'h555, 4'd5, 16'h0100);  // drive exactly 1
		queue_frame(11'h555, 4'd6, 16'h0100);
		queue_random_frames(120, sp, 1'b0);
		wait_for_quiet();

		// Phase 5: random settings, random upper bits on the id write, no idling
		write_reg(pfsc_pkg::REG_SET_POINT, pfsc_pkg::CDATA_W'($urandom));
		write_reg(pfsc_pkg::REG_KP,        pfsc_pkg::CDATA_W'($urandom_range(0, 1023)));
		write_reg(pfsc_pkg::REG_KI_DT,     pfsc_pkg::CDATA_W'($urandom_range(0, 63)));
		write_reg(pfsc_pkg::REG_KD_DIV_DT, pfsc_pkg::CDATA_W'($urandom));
		write_reg(pfsc_pkg::REG_TEMP_ID,   pfsc_pkg::CDATA_W'($urandom));
		calm = 1'b1;
		queue_random_frames(180, sp, 1'b0);
		wait_for_quiet();
		repeat (8) @(posedge clk);

		if (expected_speeds.size() != 0)
			log_mismatch("missing transaction", '0, expected_speeds[0]);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pfsc_pkg.sv
rtl/pfsc_cfg_regs.sv
rtl/pfsc_pid_dp.sv
rtl/pid_fan_speed_controller.sv
dv/tb_top.sv
